### src/bcs_pkg.sv
// Shared types and constants of the Bezier sampler.
`default_nettype none
package bcs_pkg;

   localparam int MAX_POINTS_DEF = 16;
   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int CFG_W = 6;
   localparam int IDX_W = 2;
   localparam logic [CFG_W-1:0] DIVISIONS_RESET = 6'd50;

   localparam logic [IDX_W-1:0] REG_DIVISIONS = 2'd0;
   localparam logic [IDX_W-1:0] REG_STEPS     = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T_START,
      ST_T_DIV,
      ST_LV_START,
      ST_LV_P,
      ST_EL_Q,
      ST_EL_MUL,
      ST_EL_ADD,
      ST_RD_STORE,
      ST_OUT_STORE,
      ST_OUT_LERP
   } state_type;

   typedef struct packed {
      logic store_we;
      logic rd_en;
      logic rd_work;
      logic div_init;
      logic div_step;
      logic p_load;
      logic d_load;
      logic mul;
      logic add_we;
      logic out_load;
      logic out_sel_store;
      logic out_last;
   } cmd_type;

endpackage
`default_nettype wire

### src/bcs_datapath.sv
// Datapath: point memories, parameter divider, interpolation lanes and result register.
`default_nettype none
module bcs_datapath #(
   parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = bcs_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF
) (
   input  wire                           clock,
   input  wire bcs_pkg::cmd_type         cmd,
   input  wire [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
   input  wire [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr,
   input  wire [bcs_pkg::CFG_W-1:0]      k_index,
   input  wire [bcs_pkg::CFG_W-1:0]      eff_div,
   input  wire signed [31:0]             req_point_x,
   input  wire signed [31:0]             req_point_y,
   input  wire signed [31:0]             req_point_z,
   output logic signed [31:0]            rsp_curve_x,
   output logic signed [31:0]            rsp_curve_y,
   output logic signed [31:0]            rsp_curve_z,
   output logic                          rsp_last_sample
);

   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int PW   = CW + FRAC_BITS + 2;
   localparam int DIVN = FRAC_BITS + 1 + bcs_pkg::CFG_W;
   localparam int RW   = bcs_pkg::CFG_W + 2;
   localparam logic signed [PW-1:0] HALF = PW'(64'd1 << (FRAC_BITS - 1));

   logic [3*CW-1:0] store_mem [MAX_POINTS];
   logic [3*CW-1:0] work_mem  [MAX_POINTS];
   logic [3*CW-1:0] rd_ff;

   logic [DIVN-1:0]      num_ff;
   logic [RW-1:0]        rem_ff;
   logic [FRAC_BITS:0]   t_ff;
   logic [RW-1:0]        den;
   logic [RW-1:0]        rem_sh;
   logic                 q_bit;

   logic signed [CW-1:0] p_ff    [3];
   logic signed [CW-1:0] q_ff    [3];
   logic signed [CW:0]   d_ff    [3];
   logic signed [PW-1:0] prod_ff [3];
   logic signed [CW-1:0] res_ff  [3];

   logic signed [CW-1:0] rd_lane  [3];
   logic signed [CW:0]   d_in     [3];
   logic signed [PW-1:0] prod_in  [3];
   logic signed [PW-1:0] sum_in   [3];
   logic signed [PW-1:0] sh_in    [3];
   logic signed [CW-1:0] res_in   [3];
   logic signed [CW-1:0] out_lane [3];
   logic [3*CW-1:0]      store_wdata;
   logic [3*CW-1:0]      res_packed;

   assign store_wdata = {req_point_z[CW-1:0], req_point_y[CW-1:0], req_point_x[CW-1:0]};
   assign res_packed  = {res_in[2], res_in[1], res_in[0]};

   always_ff @(posedge clock) begin
      if (cmd.store_we) begin
         store_mem[wr_addr] <= store_wdata;
      end
      if (cmd.add_we) begin
         work_mem[wr_addr] <= res_packed;
      end
      if (cmd.rd_en) begin
         rd_ff <= cmd.rd_work ? work_mem[rd_addr] : store_mem[rd_addr];
      end
   end

   // Long division of k * 2^(F+1) + D by 2D gives t rounded half up, one bit a cycle.
   assign den    = {1'b0, eff_div, 1'b0};
   assign rem_sh = {rem_ff[RW-2:0], num_ff[DIVN-1]};
   assign q_bit  = (rem_sh >= den);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         num_ff <= {k_index, (FRAC_BITS + 1)'(eff_div)};
         rem_ff <= '0;
         t_ff   <= '0;
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[DIVN-2:0], 1'b0};
         rem_ff <= q_bit ? (rem_sh - den) : rem_sh;
         t_ff   <= {t_ff[FRAC_BITS-1:0], q_bit};
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         rd_lane[l]  = rd_ff[l*CW +: CW];
         d_in[l]     = {rd_lane[l][CW-1], rd_lane[l]} - {p_ff[l][CW-1], p_ff[l]};
         prod_in[l]  = d_ff[l] * signed'({1'b0, t_ff});
         sum_in[l]   = prod_ff[l] + HALF;
         sh_in[l]    = sum_in[l] >>> FRAC_BITS;
         res_in[l]   = p_ff[l] + sh_in[l][CW-1:0];
         out_lane[l] = cmd.out_sel_store ? rd_lane[l] : res_ff[l];
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         if (cmd.p_load) begin
            p_ff[l] <= rd_lane[l];
         end else if (cmd.add_we) begin
            p_ff[l] <= q_ff[l];
         end
         if (cmd.d_load) begin
            d_ff[l] <= d_in[l];
            q_ff[l] <= rd_lane[l];
         end
         if (cmd.mul) begin
            prod_ff[l] <= prod_in[l];
         end
         if (cmd.add_we) begin
            res_ff[l] <= res_in[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_curve_x     <= 32'(out_lane[0]);
         rsp_curve_y     <= 32'(out_lane[1]);
         rsp_curve_z     <= 32'(out_lane[2]);
         rsp_last_sample <= cmd.out_last;
      end
   end

endmodule
`default_nettype wire

### src/bcs_ctrl.sv
// Controller: point loading, sample and level sequencing, result handshake and settings.
`default_nettype none
module bcs_ctrl #(
   parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
   parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire                           req_last_point,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   input  wire                           csr_we,
   input  wire [bcs_pkg::IDX_W-1:0]      csr_index,
   input  wire [bcs_pkg::CFG_W-1:0]      csr_wdata,
   output bcs_pkg::cmd_type              cmd,
   output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] rd_addr,
   output logic [((MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1)-1:0] wr_addr,
   output logic [bcs_pkg::CFG_W-1:0]     k_index,
   output logic [bcs_pkg::CFG_W-1:0]     eff_div
);

   localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int NCW  = $clog2(MAX_POINTS + 1);
   localparam int DIVN = FRAC_BITS + 1 + bcs_pkg::CFG_W;
   localparam int BCW  = $clog2(DIVN + 1);

   bcs_pkg::state_type state_ff, state_in;
   logic [bcs_pkg::CFG_W-1:0] div_ff, div_in, steps_ff, steps_in, k_ff, k_in;
   logic [NCW-1:0] cnt_ff, cnt_in, n_ff, n_in, lvl_ff, lvl_in;
   logic [AW-1:0]  i_ff, i_in;
   logic [BCW-1:0] bit_ff, bit_in;
   logic fin_ff, fin_in, out_valid_ff, out_valid_in;

   logic [bcs_pkg::CFG_W-1:0] eff_steps;
   logic has_room, full_run, k_last, sample_last, out_free, el_end, first_level;

   assign eff_div     = (div_ff == '0) ? bcs_pkg::CFG_W'(1) : div_ff;
   assign eff_steps   = (steps_ff < eff_div) ? steps_ff : eff_div;
   assign full_run    = (eff_steps == eff_div);
   assign k_last      = (k_ff == eff_steps);
   assign sample_last = k_last && !full_run;
   assign has_room    = (cnt_ff < NCW'(MAX_POINTS));
   assign out_free    = !out_valid_ff || rsp_ready;
   assign el_end      = ((NCW'(i_ff) + NCW'(2)) == lvl_ff);
   assign first_level = (lvl_ff == n_ff);
   assign k_index     = k_ff;
   assign rsp_valid   = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcs_pkg::ST_IDLE;
         div_ff       <= bcs_pkg::DIVISIONS_RESET;
         steps_ff     <= bcs_pkg::DIVISIONS_RESET;
         k_ff         <= '0;
         cnt_ff       <= '0;
         n_ff         <= '0;
         lvl_ff       <= '0;
         i_ff         <= '0;
         bit_ff       <= '0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_ff       <= div_in;
         steps_ff     <= steps_in;
         k_ff         <= k_in;
         cnt_ff       <= cnt_in;
         n_ff         <= n_in;
         lvl_ff       <= lvl_in;
         i_ff         <= i_in;
         bit_ff       <= bit_in;
         fin_ff       <= fin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      div_in   = div_ff;
      steps_in = steps_ff;
      if (csr_we) begin
         unique case (csr_index)
            bcs_pkg::REG_DIVISIONS: div_in   = csr_wdata;
            bcs_pkg::REG_STEPS:     steps_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state and sequencing counters.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      lvl_in       = lvl_ff;
      i_in         = i_ff;
      bit_in       = bit_ff;
      fin_in       = fin_ff;
      out_valid_in = cmd.out_load || (out_valid_ff && !rsp_ready);
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (has_room) begin
                  cnt_in = cnt_ff + NCW'(1);
               end
               if (req_last_point) begin
                  n_in     = has_room ? (cnt_ff + NCW'(1)) : cnt_ff;
                  k_in     = '0;
                  fin_in   = 1'b0;
                  state_in = bcs_pkg::ST_T_START;
               end
            end
         end
         bcs_pkg::ST_T_START: begin
            bit_in   = '0;
            state_in = bcs_pkg::ST_T_DIV;
         end
         bcs_pkg::ST_T_DIV: begin
            bit_in = bit_ff + BCW'(1);
            if (bit_ff == BCW'(DIVN - 1)) begin
               if (n_ff == NCW'(1)) begin
                  state_in = bcs_pkg::ST_RD_STORE;
               end else begin
                  lvl_in   = n_ff;
                  state_in = bcs_pkg::ST_LV_START;
               end
            end
         end
         bcs_pkg::ST_LV_START: state_in = bcs_pkg::ST_LV_P;
         bcs_pkg::ST_LV_P: begin
            i_in     = '0;
            state_in = bcs_pkg::ST_EL_Q;
         end
         bcs_pkg::ST_EL_Q:   state_in = bcs_pkg::ST_EL_MUL;
         bcs_pkg::ST_EL_MUL: state_in = bcs_pkg::ST_EL_ADD;
         bcs_pkg::ST_EL_ADD: begin
            if (el_end) begin
               if (lvl_ff == NCW'(2)) begin
                  state_in = bcs_pkg::ST_OUT_LERP;
               end else begin
                  lvl_in   = lvl_ff - NCW'(1);
                  state_in = bcs_pkg::ST_LV_START;
               end
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = bcs_pkg::ST_EL_Q;
            end
         end
         bcs_pkg::ST_RD_STORE: state_in = bcs_pkg::ST_OUT_STORE;
         bcs_pkg::ST_OUT_STORE, bcs_pkg::ST_OUT_LERP: begin
            if (out_free) begin
               if (fin_ff) begin
                  cnt_in   = '0;
                  state_in = bcs_pkg::ST_IDLE;
               end else if (k_last) begin
                  if (full_run) begin
                     fin_in   = 1'b1;
                     state_in = bcs_pkg::ST_RD_STORE;
                  end else begin
                     cnt_in   = '0;
                     state_in = bcs_pkg::ST_IDLE;
                  end
               end else begin
                  k_in     = k_ff + bcs_pkg::CFG_W'(1);
                  state_in = bcs_pkg::ST_T_START;
               end
            end
         end
         default: state_in = bcs_pkg::ST_IDLE;
      endcase
   end

   // Datapath commands.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rd_addr   = '0;
      wr_addr   = '0;
      unique case (state_ff)
         bcs_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.store_we = req_valid && has_room;
            wr_addr      = cnt_ff[AW-1:0];
         end
         bcs_pkg::ST_T_START: cmd.div_init = 1'b1;
         bcs_pkg::ST_T_DIV:   cmd.div_step = 1'b1;
         bcs_pkg::ST_LV_START: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_work = !first_level;
         end
         bcs_pkg::ST_LV_P: begin
            cmd.p_load  = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_work = !first_level;
            rd_addr     = AW'(1);
         end
         bcs_pkg::ST_EL_Q:   cmd.d_load = 1'b1;
         bcs_pkg::ST_EL_MUL: cmd.mul    = 1'b1;
         bcs_pkg::ST_EL_ADD: begin
            cmd.add_we = 1'b1;
            wr_addr    = i_ff;
            if (!el_end) begin
               cmd.rd_en   = 1'b1;
               cmd.rd_work = !first_level;
               rd_addr     = AW'({1'b0, i_ff} + (AW + 1)'(2));
            end
         end
         bcs_pkg::ST_RD_STORE: begin
            cmd.rd_en = 1'b1;
            rd_addr   = AW'(n_ff - NCW'(1));
         end
         bcs_pkg::ST_OUT_STORE: begin
            cmd.out_load      = out_free;
            cmd.out_sel_store = 1'b1;
            cmd.out_last      = fin_ff || sample_last;
         end
         bcs_pkg::ST_OUT_LERP: begin
            cmd.out_load = out_free;
            cmd.out_last = sample_last;
         end
         default: ;
      endcase
   end

endmodule
`default_nettype wire

### src/bezier_casteljau_sampler.sv
// Control points are taken one per cycle while idle. After the last point, each sample
// runs the parameter divider and then, per de Casteljau level, the shared interpolation
// lanes, and is then loaded into the result register; when the step count reaches the
// division count, a final repeat of the end point follows.
// Reset is synchronous: it empties the point count, sets both settings to 50 and drops
// any pending beat; the point memories keep their contents.
`default_nettype none
module bezier_casteljau_sampler #(
   parameter int MAX_POINTS = bcs_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = bcs_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = bcs_pkg::FRAC_BITS_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire signed [31:0]         req_point_x,
   input  wire signed [31:0]         req_point_y,
   input  wire signed [31:0]         req_point_z,
   input  wire                       req_last_point,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic signed [31:0]        rsp_curve_x,
   output logic signed [31:0]        rsp_curve_y,
   output logic signed [31:0]        rsp_curve_z,
   output logic                      rsp_last_sample,
   input  wire                       csr_we,
   input  wire [bcs_pkg::IDX_W-1:0]  csr_index,
   input  wire [bcs_pkg::CFG_W-1:0]  csr_wdata
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

   bcs_pkg::cmd_type          cmd;
   logic [AW-1:0]             rd_addr;
   logic [AW-1:0]             wr_addr;
   logic [bcs_pkg::CFG_W-1:0] k_index;
   logic [bcs_pkg::CFG_W-1:0] eff_div;

   bcs_ctrl #(
      .MAX_POINTS(MAX_POINTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_last_point (req_last_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .wr_addr        (wr_addr),
      .k_index        (k_index),
      .eff_div        (eff_div)
   );

   bcs_datapath #(
      .MAX_POINTS(MAX_POINTS),
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr),
      .k_index         (k_index),
      .eff_div         (eff_div),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .rsp_curve_x     (rsp_curve_x),
      .rsp_curve_y     (rsp_curve_y),
      .rsp_curve_z     (rsp_curve_z),
      .rsp_last_sample (rsp_last_sample)
   );

endmodule
`default_nettype wire
